@@ design/sca_pkg.sv @@
// Shared types, codes and defaults for the size-class slab allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sca_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int MAX_SPANS_DEF = 8;
  localparam int ADDR_BITS_DEF = 32;

  // field widths fixed by the interface
  localparam int AW     = 32;
  localparam int OSZ_W  = 16;
  localparam int CAL_W  = 13;
  localparam int OPS_W  = 11;
  localparam int SPB_W  = 25;
  localparam int CNT_W  = 11;
  localparam int SPO_W  = 4;
  localparam int DV_W   = 27;  // offset inside a span's slot area
  localparam int IX_W   = DV_W + 1;
  localparam int CIX_W  = 3;

  localparam logic [1:0] A_ALLOC = 2'd0;
  localparam logic [1:0] A_FREE  = 2'd1;
  localparam logic [1:0] A_QUERY = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_SPACE    = 3'd2;
  localparam logic [2:0] ST_NOTOWN   = 3'd3;
  localparam logic [2:0] ST_BOUND    = 3'd4;
  localparam logic [2:0] ST_NOTALLOC = 3'd5;
  localparam logic [2:0] ST_NULL     = 3'd6;

  localparam logic [CIX_W-1:0] CFG_BASE  = 3'd0;
  localparam logic [CIX_W-1:0] CFG_OSIZE = 3'd1;
  localparam logic [CIX_W-1:0] CFG_CALIGN = 3'd2;
  localparam logic [CIX_W-1:0] CFG_OPS   = 3'd3;
  localparam logic [CIX_W-1:0] CFG_SPB   = 3'd4;

  localparam logic [OSZ_W-1:0] OSIZE_RST  = 16'd64;
  localparam logic [CAL_W-1:0] CALIGN_RST = 13'd16;
  localparam logic [OPS_W-1:0] OPS_RST    = 11'd64;
  localparam logic [SPB_W-1:0] SPB_RST    = 25'd4096;

endpackage

@@ design/size_class_slab_allocator.sv @@
// Top level of the size-class slab allocator: free stack and allocated map
// memories, span scan and control sequencer. Depends on sca_pkg and sca_div.
//
// Usage: an item (action, address, request_size, request_alignment) is taken
// at a clock edge with start high and busy low. Busy stays high while the item
// is worked on and drops as the result is shown: out_valid is high for exactly
// one cycle with ok, status, object_address and the counts; the receiver
// cannot stall it. The next item may be started in the cycle of the strobe.
// Configuration writes go over cfg_valid/cfg_ready (always ready) with
// cfg_index selecting the register; write only while the block is idle.
// Work after the accepting edge: a rejected request, null address or unknown
// action is answered from the idle state; a query, or a free that fails the
// span scan, walks every span in use and then posts its result; a free or an
// allocate that divides also runs the serial divider (ending with its done
// strobe) and, when the slot has a map entry, the map read-modify-write. An
// allocate from an empty stack first grows a span, pushing one slot per cycle
// through the stack memory port (grow may be refused for lack of space).
// After reset the allocated map is cleared one entry per cycle over all
// MAX_SLOTS entries (busy high); configuration writes are taken meanwhile.
`timescale 1ns / 1ps
module size_class_slab_allocator
  import sca_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int MAX_SPANS = MAX_SPANS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_action,
  input  logic [AW-1:0]    in_address,
  input  logic [OSZ_W-1:0] in_request_size,
  input  logic [CAL_W-1:0] in_request_alignment,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CIX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  output logic             out_ok,
  output logic [AW-1:0]    out_object_address,
  output logic [2:0]       out_status,
  output logic [CNT_W-1:0] out_allocated_objects,
  output logic [CNT_W-1:0] out_free_objects,
  output logic [CNT_W-1:0] out_capacity_objects,
  output logic [SPO_W-1:0] out_spans_in_use
);

  localparam int TOP_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int SPN_W = $clog2(MAX_SPANS + 1);
  localparam int F_W   = ((SPN_W + SPB_W > AW) ? SPN_W + SPB_W : AW) + 2;
  localparam int LIM_SH = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [F_W-1:0] LIMIT = F_W'(1) << LIM_SH;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_G0   = 4'd2;
  localparam logic [3:0] S_G1   = 4'd3;
  localparam logic [3:0] S_GROW = 4'd4;
  localparam logic [3:0] S_POP  = 4'd5;
  localparam logic [3:0] S_POPW = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_POST = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_MAP  = 4'd10;

  // configuration
  logic [AW-1:0]    base_r;
  logic [OSZ_W-1:0] osize_r;
  logic [CAL_W-1:0] calign_r;
  logic [OPS_W-1:0] ops_r;
  logic [SPB_W-1:0] spb_r;
  logic [DV_W-1:0]  bytes_r;

  // memories
  logic [AW-1:0] stack_mem [MAX_SLOTS];
  logic          map_mem   [MAX_SLOTS];
  logic [AW-1:0] stk_rd_r;
  logic          map_rd_r;
  logic             stk_we, map_we, map_wd;
  logic [IDX_W-1:0] stk_wa, stk_ra, map_wa, map_ra;
  logic [AW-1:0]    stk_wd;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [TOP_W-1:0] top_r, top_nxt, live_r, live_nxt, cap_r, cap_nxt;
  logic [SPN_W-1:0] spans_r, spans_nxt, si_r, si_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt, idx_r, idx_nxt;
  logic [AW-1:0]    gaddr_r, gaddr_nxt;
  logic [OPS_W-1:0] gcnt_r, gcnt_nxt;
  logic [F_W-1:0]   f_r, f_nxt, gstart_r, gstart_nxt;
  logic [IX_W-1:0]  bidx_r, bidx_nxt, fbidx_r, fbidx_nxt;
  logic             own_r, own_nxt, fnd_r, fnd_nxt;
  logic [DV_W-1:0]  d_r, d_nxt;
  logic             ov_r, ov_nxt, ook_r, ook_nxt;
  logic [AW-1:0]    oaddr_r, oaddr_nxt;
  logic [2:0]       ost_r, ost_nxt;

  logic             fin, fin_give;
  logic [2:0]       fin_st;
  logic             req_bad, hit_own, hit_bnd, div_go, div_done;
  logic [F_W-1:0]   a_ext, dd;
  logic [IX_W-1:0]  idx_full;
  logic [DV_W-1:0]  div_q;
  logic [OSZ_W-1:0] div_r;

  sca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (d_r),
    .divisor  (osize_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      osize_r  <= OSIZE_RST;
      calign_r <= CALIGN_RST;
      ops_r    <= OPS_RST;
      spb_r    <= SPB_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE:   base_r   <= cfg_data;
        CFG_OSIZE:  osize_r  <= cfg_data[OSZ_W-1:0];
        CFG_CALIGN: calign_r <= cfg_data[CAL_W-1:0];
        CFG_OPS:    ops_r    <= cfg_data[OPS_W-1:0];
        CFG_SPB:    spb_r    <= cfg_data[SPB_W-1:0];
        default: ;
      endcase
    end
    bytes_r <= DV_W'(ops_r) * DV_W'(osize_r);
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stack_mem[stk_ra];
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_r <= map_mem[map_ra];
  end

  assign req_bad = (in_request_size == '0) || (in_request_size > osize_r) ||
                   (in_request_alignment == '0) ||
                   ((in_request_alignment & (in_request_alignment - 1'b1)) != '0) ||
                   (in_request_alignment > calign_r) ||
                   ((calign_r & (in_request_alignment - 1'b1)) != '0);

  assign a_ext    = F_W'(addr_r);
  assign dd       = a_ext - f_r;
  assign hit_own  = (a_ext >= f_r) && (a_ext < f_r + F_W'(spb_r));
  assign hit_bnd  = (a_ext >= f_r) && (dd < F_W'(bytes_r)) && (osize_r != '0);
  assign idx_full = fbidx_r + IX_W'(div_q);

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    addr_nxt   = addr_r;
    top_nxt    = top_r;
    live_nxt   = live_r;
    cap_nxt    = cap_r;
    spans_nxt  = spans_r;
    si_nxt     = si_r;
    clr_nxt    = clr_r;
    idx_nxt    = idx_r;
    gaddr_nxt  = gaddr_r;
    gcnt_nxt   = gcnt_r;
    f_nxt      = f_r;
    gstart_nxt = gstart_r;
    bidx_nxt   = bidx_r;
    fbidx_nxt  = fbidx_r;
    own_nxt    = own_r;
    fnd_nxt    = fnd_r;
    d_nxt      = d_r;
    ov_nxt     = 1'b0;
    ook_nxt    = ook_r;
    oaddr_nxt  = oaddr_r;
    ost_nxt    = ost_r;
    stk_we = 1'b0; stk_wa = top_r[IDX_W-1:0]; stk_wd = gaddr_r; stk_ra = '0;
    map_we = 1'b0; map_wa = clr_r; map_wd = 1'b0; map_ra = idx_full[IDX_W-1:0];
    fin = 1'b0; fin_st = ST_OK; fin_give = 1'b0; div_go = 1'b0;

    case (state_r)
      S_CLR: begin
        map_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(MAX_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          addr_nxt = in_address;
          f_nxt    = F_W'(base_r);
          si_nxt   = '0;
          bidx_nxt = '0;
          own_nxt  = 1'b0;
          fnd_nxt  = 1'b0;
          case (in_action)
            A_ALLOC: begin
              if (req_bad) begin
                fin = 1'b1; fin_st = ST_BAD;
              end else if (top_r == '0) begin
                state_nxt = S_G0;
              end else begin
                state_nxt = S_POP;
              end
            end
            A_FREE, A_QUERY: begin
              if (in_address == '0) begin
                fin = 1'b1; fin_st = ST_NULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1; fin_st = ST_BAD;
            end
          endcase
        end
      end
      S_G0: begin
        gstart_nxt = F_W'(base_r) + F_W'(spans_r) * F_W'(spb_r);
        state_nxt  = S_G1;
      end
      S_G1: begin
        if ((32'(spans_r) >= 32'(MAX_SPANS)) || (ops_r == '0) || (spb_r == '0) ||
            (32'(cap_r) + 32'(ops_r) > 32'(MAX_SLOTS)) ||
            (bytes_r > DV_W'(spb_r)) || (gstart_r == '0) ||
            (gstart_r + F_W'(spb_r) > LIMIT)) begin
          fin = 1'b1; fin_st = ST_SPACE;
        end else begin
          gaddr_nxt = gstart_r[AW-1:0];
          gcnt_nxt  = '0;
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        // push one slot address per cycle, ascending
        if (32'(top_r) < 32'(MAX_SLOTS)) begin
          stk_we  = 1'b1;
          top_nxt = top_r + 1'b1;
        end
        gaddr_nxt = gaddr_r + AW'(osize_r);
        gcnt_nxt  = gcnt_r + 1'b1;
        if (gcnt_r == ops_r - 1'b1) begin
          spans_nxt = spans_r + 1'b1;
          cap_nxt   = cap_r + TOP_W'(ops_r);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (top_r == '0) begin
          fin = 1'b1; fin_st = ST_SPACE;
        end else begin
          stk_ra    = IDX_W'(top_r - 1'b1);
          top_nxt   = top_r - 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        addr_nxt  = stk_rd_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (si_r == spans_r) begin
          state_nxt = S_POST;
        end else begin
          if (hit_own) own_nxt = 1'b1;
          if (hit_bnd && !fnd_r) begin
            fnd_nxt   = 1'b1;
            d_nxt     = DV_W'(dd);
            fbidx_nxt = bidx_r;
          end
          f_nxt    = f_r + F_W'(spb_r);
          bidx_nxt = bidx_r + IX_W'(ops_r);
          si_nxt   = si_r + 1'b1;
        end
      end
      S_POST: begin
        case (act_r)
          A_ALLOC: begin
            if (fnd_r) begin
              div_go = 1'b1; state_nxt = S_DIV;
            end else begin
              live_nxt = live_r + 1'b1;
              fin = 1'b1; fin_give = 1'b1;
            end
          end
          A_FREE: begin
            if (!own_r) begin
              fin = 1'b1; fin_st = ST_NOTOWN;
            end else if (!fnd_r) begin
              fin = 1'b1; fin_st = ST_BOUND;
            end else begin
              div_go = 1'b1; state_nxt = S_DIV;
            end
          end
          default: begin
            fin = 1'b1; fin_st = own_r ? ST_OK : ST_NOTOWN;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          if (div_r != '0 || idx_full >= IX_W'(MAX_SLOTS)) begin
            // no map entry to track: allocate succeeds, free fails
            fin = 1'b1;
            if (act_r == A_ALLOC) begin
              live_nxt = live_r + 1'b1;
              fin_give = 1'b1;
            end else begin
              fin_st = (div_r != '0) ? ST_BOUND : ST_NOTALLOC;
            end
          end else begin
            idx_nxt   = idx_full[IDX_W-1:0];
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        map_wa = idx_r;
        fin    = 1'b1;
        if (act_r == A_ALLOC) begin
          if (map_rd_r) begin
            top_nxt = top_r + 1'b1;  // slot already out: put it back
            fin_st  = ST_SPACE;
          end else begin
            map_we = 1'b1; map_wd = 1'b1;
            live_nxt = live_r + 1'b1;
            fin_give = 1'b1;
          end
        end else begin
          if (!map_rd_r) begin
            fin_st = ST_NOTALLOC;
          end else begin
            if (32'(top_r) < 32'(MAX_SLOTS)) begin
              stk_we  = 1'b1;
              stk_wd  = addr_r;
              top_nxt = top_r + 1'b1;
            end
            map_we = 1'b1;
            if (live_r != '0) live_nxt = live_r - 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      ov_nxt    = 1'b1;
      ook_nxt   = (fin_st == ST_OK);
      ost_nxt   = fin_st;
      oaddr_nxt = fin_give ? addr_r : '0;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      top_r   <= '0;
      live_r  <= '0;
      cap_r   <= '0;
      spans_r <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      live_r  <= live_nxt;
      cap_r   <= cap_nxt;
      spans_r <= spans_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    act_r    <= act_nxt;
    addr_r   <= addr_nxt;
    si_r     <= si_nxt;
    idx_r    <= idx_nxt;
    gaddr_r  <= gaddr_nxt;
    gcnt_r   <= gcnt_nxt;
    f_r      <= f_nxt;
    gstart_r <= gstart_nxt;
    bidx_r   <= bidx_nxt;
    fbidx_r  <= fbidx_nxt;
    own_r    <= own_nxt;
    fnd_r    <= fnd_nxt;
    d_r      <= d_nxt;
    ook_r    <= ook_nxt;
    oaddr_r  <= oaddr_nxt;
    ost_r    <= ost_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = ov_r;
  assign out_ok                = ook_r;
  assign out_object_address    = oaddr_r;
  assign out_status            = ost_r;
  assign out_allocated_objects = CNT_W'(live_r);
  assign out_free_objects      = CNT_W'(top_r);
  assign out_capacity_objects  = CNT_W'(cap_r);
  assign out_spans_in_use      = SPO_W'(spans_r);

endmodule

@@ design/sca_div.sv @@
// Restoring divider, one quotient bit per cycle, for slot offset / object size.
// Depends on sca_pkg.
`timescale 1ns / 1ps
module sca_div
  import sca_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DV_W-1:0]  dividend,
  input  logic [OSZ_W-1:0] divisor,
  output logic             done,
  output logic [DV_W-1:0]  quot,
  output logic [OSZ_W-1:0] rem
);

  localparam int C_W = $clog2(DV_W + 1);

  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic [OSZ_W:0] rem_r, rem_nxt;
  logic [DV_W-1:0] quo_r, quo_nxt;
  logic [OSZ_W:0] sh;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    sh       = {rem_r[OSZ_W-1:0], quo_r[DV_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (run_r) begin
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = sh - {1'b0, divisor};
        quo_nxt = {quo_r[DV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[DV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == C_W'(DV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r[OSZ_W-1:0];

endmodule

@@ design/sca_checker.sv @@
// Port-level checks for the slab allocator, bound to the top level.
// Depends on sca_pkg and size_class_slab_allocator.
`timescale 1ns / 1ps
module sca_checker
  import sca_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input logic          out_ok,
  input logic [AW-1:0] out_object_address,
  input logic [2:0]    out_status
);

  // an item rejected on acceptance shows its result at once without busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transfer did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without work in progress");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == ST_OK)))
    else $error("ok disagrees with status");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_object_address == '0))
    else $error("failed result carries an address");

endmodule

bind size_class_slab_allocator sca_checker u_sca_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_ok             (out_ok),
  .out_object_address (out_object_address),
  .out_status         (out_status)
);
